// ===== hw/rtl/qtsv_pkg.sv =====
`default_nettype none

package qtsv_pkg;

    localparam int unsigned QTSV_CHAR_W = 16;
    localparam int unsigned QTSV_QUEUE_DEPTH = 2;

    localparam logic [QTSV_CHAR_W-1:0] CHAR_TAB   = 16'h0009;
    localparam logic [QTSV_CHAR_W-1:0] CHAR_CR    = 16'h000D;
    localparam logic [QTSV_CHAR_W-1:0] CHAR_LF    = 16'h000A;
    localparam logic [QTSV_CHAR_W-1:0] CHAR_QUOTE = 16'h0022;
    localparam logic [QTSV_CHAR_W-1:0] CHAR_END   = 16'hFFFF;

    typedef enum logic [2:0] {
        CLS_OTHER = 3'd0,
        CLS_TAB   = 3'd1,
        CLS_CR    = 3'd2,
        CLS_LF    = 3'd3,
        CLS_QUOTE = 3'd4,
        CLS_END   = 3'd5
    } char_class_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_FIELD  = 2'd2,
        ACT_ROW    = 2'd3
    } action_t;

    typedef enum logic [5:0] {
        ST_START     = 6'b000001,
        ST_PLAIN     = 6'b000010,
        ST_PLAIN_CR  = 6'b000100,
        ST_QUOTED    = 6'b001000,
        ST_QUOTE_SEEN = 6'b010000,
        ST_QUOTE_CR  = 6'b100000
    } lex_state_t;

    typedef struct packed {
        char_class_t             cls;
        logic [QTSV_CHAR_W-1:0]  ch;
    } lex_item_t;

    typedef struct packed {
        action_t                 action;
        logic [QTSV_CHAR_W-1:0]  ch;
        logic                    done;
    } lex_result_t;

    typedef struct packed {
        lex_state_t next;
        action_t    action;
    } lex_step_t;

    function automatic char_class_t classify(input logic [QTSV_CHAR_W-1:0] ch,
                                             input logic end_mark);
        char_class_t cls;
        if (end_mark || ch == CHAR_END) begin
            cls = CLS_END;
        end else begin
            case (ch)
                CHAR_TAB:   cls = CLS_TAB;
                CHAR_CR:    cls = CLS_CR;
                CHAR_LF:    cls = CLS_LF;
                CHAR_QUOTE: cls = CLS_QUOTE;
                default:    cls = CLS_OTHER;
            endcase
        end
        return cls;
    endfunction

    function automatic lex_step_t lex_step(input lex_state_t st, input char_class_t cls);
        lex_step_t r;
        r.next   = ST_START;
        r.action = ACT_NONE;
        unique case (st)
            ST_PLAIN:
            begin
                unique case (cls)
                    CLS_TAB:   r = '{ST_START, ACT_FIELD};
                    CLS_CR:    r = '{ST_PLAIN_CR, ACT_NONE};
                    CLS_END:   r = '{ST_START, ACT_FIELD};
                    default:   r = '{ST_PLAIN, ACT_APPEND};
                endcase
            end
            ST_PLAIN_CR:
            begin
                unique case (cls)
                    CLS_TAB:   r = '{ST_START, ACT_FIELD};
                    CLS_CR:    r = '{ST_PLAIN_CR, ACT_NONE};
                    CLS_LF:    r = '{ST_START, ACT_ROW};
                    CLS_END:   r = '{ST_START, ACT_NONE};
                    default:   r = '{ST_PLAIN, ACT_APPEND};
                endcase
            end
            ST_QUOTED:
            begin
                unique case (cls)
                    CLS_QUOTE: r = '{ST_QUOTE_SEEN, ACT_NONE};
                    CLS_END:   r = '{ST_START, ACT_FIELD};
                    default:   r = '{ST_QUOTED, ACT_APPEND};
                endcase
            end
            ST_QUOTE_SEEN:
            begin
                unique case (cls)
                    CLS_TAB:   r = '{ST_START, ACT_FIELD};
                    CLS_CR:    r = '{ST_QUOTE_CR, ACT_NONE};
                    CLS_QUOTE: r = '{ST_QUOTED, ACT_APPEND};
                    CLS_END:   r = '{ST_START, ACT_FIELD};
                    default:   r = '{ST_PLAIN, ACT_APPEND};
                endcase
            end
            ST_QUOTE_CR:
            begin
                unique case (cls)
                    CLS_TAB:   r = '{ST_START, ACT_FIELD};
                    CLS_LF:    r = '{ST_START, ACT_ROW};
                    CLS_END:   r = '{ST_START, ACT_FIELD};
                    default:   r = '{ST_PLAIN, ACT_APPEND};
                endcase
            end
            default:
            begin
                unique case (cls)
                    CLS_TAB:   r = '{ST_START, ACT_FIELD};
                    CLS_CR:    r = '{ST_PLAIN_CR, ACT_NONE};
                    CLS_QUOTE: r = '{ST_QUOTED, ACT_NONE};
                    CLS_END:   r = '{ST_START, ACT_NONE};
                    default:   r = '{ST_PLAIN, ACT_APPEND};
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qtsv_fifo.sv =====
`default_nettype none

module qtsv_fifo
    import qtsv_pkg::*;
#(
    parameter int unsigned Width = 1,
    parameter int unsigned Depth = QTSV_QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [Width-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [Width-1:0]      rd_data,
    output logic                  empty
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    logic [Width-1:0] mem_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/qtsv_front.sv =====
`default_nettype none

module qtsv_front
    import qtsv_pkg::*;
(
    input  wire logic [QTSV_CHAR_W-1:0] text_char,
    input  wire logic                   end_of_text,
    output lex_item_t                   item
);

    always_comb
    begin
        item.cls = classify(text_char, end_of_text);
        item.ch  = text_char;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/qtsv_back.sv =====
`default_nettype none

module qtsv_back
    import qtsv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire lex_item_t in_item,
    input  wire logic      in_empty,
    output logic           in_pop,
    input  wire logic      out_full,
    output logic           out_push,
    output lex_result_t    out_result
);

    lex_state_t state_reg, state_next;
    lex_step_t  step;

    assign step     = lex_step(state_reg, in_item.cls);
    assign in_pop   = !in_empty && !out_full;
    assign out_push = in_pop;

    always_comb
    begin
        out_result.action = step.action;
        out_result.ch     = (step.action == ACT_APPEND) ? in_item.ch : '0;
        out_result.done   = (in_item.cls == CLS_END);
        state_next        = in_pop ? step.next : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/quoted_tsv_field_lexer_core.sv =====
// Tab-separated text lexer with quoted fields. Push one 16-bit character per
// beat (end_of_text, or the character 0xFFFF, ends the text); every beat
// yields exactly one result with an action (none, append out_char, new field,
// new row) and text_done set on the beat that ended the text, after which the
// lexer starts over. The block takes one character per cycle with no gaps
// while results are popped as they appear; a result passes through the
// classified character queue and then the result queue, each QueueDepth
// beats deep. A full queue takes nothing in the cycle it is popped, so the
// input does not take characters again at once when a stalled output resumes.
`default_nettype none

module quoted_tsv_field_lexer_core
    import qtsv_pkg::*;
#(
    parameter int unsigned QueueDepth = QTSV_QUEUE_DEPTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [QTSV_CHAR_W-1:0] text_char,
    input  wire logic                   end_of_text,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [1:0]                  action,
    output logic [QTSV_CHAR_W-1:0]      out_char,
    output logic                        text_done
);

    localparam int unsigned ItemW   = $bits(lex_item_t);
    localparam int unsigned ResultW = $bits(lex_result_t);

    lex_item_t   front_item;
    lex_item_t   mid_item;
    logic        mid_empty;
    logic        mid_pop;
    logic        res_full;
    logic        res_push;
    lex_result_t res_in;
    lex_result_t res_out;

    qtsv_front u_front
    (
        .text_char   (text_char),
        .end_of_text (end_of_text),
        .item        (front_item)
    );

    qtsv_fifo #(
        .Width (ItemW),
        .Depth (QueueDepth)
    ) u_item_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_item),
        .full    (full),
        .rd_en   (mid_pop),
        .rd_data (mid_item),
        .empty   (mid_empty)
    );

    qtsv_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (mid_item),
        .in_empty   (mid_empty),
        .in_pop     (mid_pop),
        .out_full   (res_full),
        .out_push   (res_push),
        .out_result (res_in)
    );

    qtsv_fifo #(
        .Width (ResultW),
        .Depth (QueueDepth)
    ) u_result_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign action    = res_out.action;
    assign out_char  = res_out.ch;
    assign text_done = res_out.done;

    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result written into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) mid_pop |-> !mid_empty)
        else $error("item taken from an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && action != ACT_APPEND) |-> (out_char == '0))
        else $error("character shown on a result that appends nothing");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && text_done) |-> (action != ACT_APPEND && action != ACT_ROW))
        else $error("end of text gave an append or a new row");

endmodule

`default_nettype wire
